>>> hw/rtl/rls_pkg.sv
// shared types and constants for the linear ramp smoother
// no dependencies

package rls_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int TICK_BITS     = 16;
   localparam int CSR_BITS      = 16;
   localparam int CMD_BITS      = 2;
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + 1 + 7) / 8) * 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = 1;
   localparam int QCNT_BITS     = 2;

   localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SET  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_ADD  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_LOAD = 2'd3;

   typedef struct packed {
      logic                          is_tick;
      logic                          is_target;
      logic                          is_add;
      logic signed [VALUE_BITS-1:0]  value;
   } op_type;

endpackage

>>> hw/rtl/rls_front.sv
// front end: takes request transactions and decodes the command
// depends on rls_pkg

module rls_front
   import rls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // value_in
   input  logic [CMD_BITS-1:0]      req_tuser,   // cmd
   output logic                     op_valid,
   input  logic                     op_ready,
   output op_type                   op
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   take;

   assign req_tready = !valid_ff || op_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      op_in           = op_ff;
      valid_in        = valid_ff;
      if (op_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in        = 1'b1;
         op_in.is_tick   = 1'b0;
         op_in.is_target = 1'b0;
         op_in.is_add    = 1'b0;
         op_in.value     = $signed(req_tdata[VALUE_BITS-1:0]);
         unique case (req_tuser)
            CMD_TICK: begin
               op_in.is_tick = 1'b1;
               op_in.value   = '0;
            end
            CMD_SET: begin
               op_in.is_target = 1'b1;
            end
            CMD_ADD: begin
               op_in.is_target = 1'b1;
               op_in.is_add    = 1'b1;
            end
            CMD_LOAD: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end

   assign op_valid = valid_ff;
   assign op       = op_ff;

endmodule

>>> hw/rtl/rls_queue.sv
// two-entry queue between the decode front and the execution back end
// depends on rls_pkg

module rls_queue
   import rls_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   op_type                q_mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]  count_ff;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_ready && pop_valid;
   assign pop_op     = q_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         q_mem[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> hw/rtl/rls_back.sv
// back end: ramp state, bit-serial step divider, tick multiplier, result register
// depends on rls_pkg

module rls_back
   import rls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   output logic                     op_ready,
   input  op_type                   op,
   input  logic [TICK_BITS-1:0]     ramp_ticks,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam int PAD_BITS = RSP_DATA_BITS - VALUE_BITS - 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SUB  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic signed [VALUE_BITS-1:0] cur_ff, cur_in;
   logic signed [VALUE_BITS-1:0] tgt_ff, tgt_in;
   logic signed [VALUE_BITS:0]   step_ff, step_in;
   logic [TICK_BITS-1:0]         left_ff, left_in;
   logic [VALUE_BITS-1:0]        prod_ff, prod_in;
   logic                         neg_ff, neg_in;
   logic [VALUE_BITS-1:0]        dvd_ff, dvd_in;
   logic [TICK_BITS-1:0]         rem_ff, rem_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]        out_value_ff, out_value_in;
   logic                         out_ramp_ff, out_ramp_in;

   logic                         out_free, done;
   logic signed [VALUE_BITS:0]   sum, diff_up, diff_dn;
   logic signed [VALUE_BITS-1:0] sat_sum;
   logic [TICK_BITS:0]           rem_sh, rem_sub;
   logic                         rem_ge;
   logic signed [VALUE_BITS+TICK_BITS+1:0] prod_full;

   assign out_free = !out_valid_ff || rsp_tready;

   assign sum     = {op.value[VALUE_BITS-1], op.value} + {tgt_ff[VALUE_BITS-1], tgt_ff};
   assign sat_sum = (sum[VALUE_BITS] != sum[VALUE_BITS-1])
                  ? {sum[VALUE_BITS], {(VALUE_BITS-1){~sum[VALUE_BITS]}}}
                  : sum[VALUE_BITS-1:0];

   assign diff_up = {tgt_ff[VALUE_BITS-1], tgt_ff} - {cur_ff[VALUE_BITS-1], cur_ff};
   assign diff_dn = {cur_ff[VALUE_BITS-1], cur_ff} - {tgt_ff[VALUE_BITS-1], tgt_ff};

   assign rem_sh  = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, ramp_ticks};
   assign rem_ge  = rem_sh >= {1'b0, ramp_ticks};

   assign prod_full = step_ff * $signed({1'b0, left_ff});

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      op_ready = 1'b0;
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid && out_free) begin
               op_ready = 1'b1;
               priority if (op.is_tick) begin
                  if (left_ff == '0) begin
                     done = 1'b1;
                  end else begin
                     left_in  = left_ff - 1'b1;
                     state_in = ST_MUL;
                  end
               end else if (op.is_target) begin
                  tgt_in   = op.is_add ? sat_sum : op.value;
                  state_in = ST_PREP;
               end else begin
                  cur_in  = op.value;
                  tgt_in  = op.value;
                  step_in = '0;
                  left_in = '0;
                  done    = 1'b1;
               end
            end
         end
         ST_PREP: begin
            if (ramp_ticks == '0) begin
               cur_in   = tgt_ff;
               step_in  = '0;
               left_in  = '0;
               done     = 1'b1;
               state_in = ST_IDLE;
            end else if (diff_up == '0) begin
               step_in  = '0;
               left_in  = '0;
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               left_in  = ramp_ticks;
               neg_in   = diff_up[VALUE_BITS];
               dvd_in   = diff_up[VALUE_BITS] ? diff_dn[VALUE_BITS-1:0]
                                              : diff_up[VALUE_BITS-1:0];
               rem_in   = '0;
               count_in = CNT_BITS'(VALUE_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_sub[TICK_BITS-1:0] : rem_sh[TICK_BITS-1:0];
            dvd_in = {dvd_ff[VALUE_BITS-2:0], rem_ge};
            if (count_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_FIN: begin
            step_in  = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            prod_in  = prod_full[VALUE_BITS-1:0];
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cur_in   = tgt_ff - $signed(prod_ff);
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_ramp_in  = out_ramp_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (done) begin
         out_valid_in = 1'b1;
         out_value_in = cur_in;
         out_ramp_in  = left_in != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         tgt_ff       <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      count_ff     <= count_in;
      out_value_ff <= out_value_in;
      out_ramp_ff  <= out_ramp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, out_ramp_ff, out_value_ff};

endmodule

>>> hw/rtl/linear_ramp_smoother_top.sv
// linear ramp smoother for a signed Q16.16 parameter
// req transactions carry a command (tuser) and a value (tdata); each gives one rsp transaction
// csr writes set the ramp length in ticks; write it only while no transaction is in flight
// commands: tick, set target, add to target (saturating), reset to value
// a new target ramps from the current value over ramp_ticks ticks, landing exactly on it
// req goes through a decode register and a two-entry queue to the execution unit
// cycles per transaction in the execution unit, set by its state sequence:
//   1 for reset to value or a tick with no ramp running
//   2 for set or add that starts no ramp
//   3 for a tick during a ramp (multiply, then subtract)
//   35 for set or add that starts a ramp (32-cycle bit-serial step divider)
// latency from req to rsp is these figures plus two cycles
// reset clears level, target, step and tick count to zero and ramp_ticks to zero
// when rsp_tready is low the result holds in the output register, the unit stops,
// and req keeps being taken until the queue and the decode register are full
// depends on rls_pkg, rls_front, rls_queue, rls_back

module linear_ramp_smoother_top
   import rls_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // value_in
   input  logic [CMD_BITS-1:0]      req_tuser,   // cmd
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // value_out, ramping, zero pad
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_BITS-1:0]      csr_data     // ramp_ticks
);

   logic [TICK_BITS-1:0] ramp_ticks_ff;
   logic                 front_valid, front_ready;
   op_type               front_op;
   logic                 back_valid, back_ready;
   op_type               back_op;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ticks_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         ramp_ticks_ff <= csr_data[TICK_BITS-1:0];
      end
   end

   rls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (front_valid),
      .op_ready   (front_ready),
      .op         (front_op)
   );

   rls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_op    (front_op),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_op     (back_op)
   );

   rls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (back_valid),
      .op_ready   (back_ready),
      .op         (back_op),
      .ramp_ticks (ramp_ticks_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/tb_linear_ramp_smoother_top.sv
// self-checking testbench for linear_ramp_smoother_top: a directed table, then random
// command phases under several ramp lengths, checked against an in-bench level predictor
// depends on rls_pkg and linear_ramp_smoother_top
`timescale 1ns / 1ps

module tb_linear_ramp_smoother_top
   import rls_pkg::*;
();

   localparam longint LEVEL_MAX    = 64'sd2147483647;
   localparam longint LEVEL_MIN    = -LEVEL_MAX - 1;
   localparam int     PLAN_ROWS    = 30;
   localparam int     PHASES       = 10;
   localparam int     PHASE_ITEMS  = 55;
   localparam int     SETTLE_TICKS = 40;

   typedef struct packed {
      logic [VALUE_BITS-1:0] level;
      logic                  ramping;
   } level_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CMD_BITS-1:0]   cmd;
      logic [VALUE_BITS-1:0] value;
      logic                  typed;
      level_type             want;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [CMD_BITS-1:0]      req_tuser = CMD_TICK;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_BITS-1:0]      csr_data = '0;

   // predictor state
   longint level_now;
   longint level_goal;
   longint ramp_step;
   int     ticks_to_go;
   int     ramp_len;

   level_type levels_due[$];
   int        errors = 0;
   bit        req_gaps = 1'b1;
   bit        rsp_stalls = 1'b1;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_SET,  32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 1'b0}},
      '{ROW_ITEM, CMD_ADD,  32'h0000_0001, 1'b1, '{32'h7fff_ffff, 1'b0}},
      '{ROW_ITEM, CMD_LOAD, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0}},
      '{ROW_ITEM, CMD_ADD,  32'hffff_ffff, 1'b1, '{32'h8000_0000, 1'b0}},
      '{ROW_CSR,  CMD_TICK, 32'h0000_0004, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_SET,  32'h7fff_ffff, 1'b1, '{32'h8000_0000, 1'b1}},
      '{ROW_ITEM, CMD_TICK, 32'ha5a5_a5a5, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h5a5a_5a5a, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'hffff_ffff, 1'b1, '{32'h7fff_ffff, 1'b0}},
      '{ROW_ITEM, CMD_SET,  32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 1'b0}},
      '{ROW_ITEM, CMD_SET,  32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_CSR,  CMD_TICK, 32'h0000_0002, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_ADD,  32'h0064_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_LOAD, 32'hffff_fffb, 1'b1, '{32'hffff_fffb, 1'b0}},
      '{ROW_CSR,  CMD_TICK, 32'h0000_ffff, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_SET,  32'h0000_0001, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_ADD,  32'h8000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_ADD,  32'h8000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_CSR,  CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_TICK, 32'h0000_0000, 1'b0, '{32'h0000_0000, 1'b0}},
      '{ROW_ITEM, CMD_SET,  32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b0}}
   };

   linear_ramp_smoother_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
   endtask

   // new target: snap, hold, or start a ramp from the current level
   function automatic void retarget(input longint goal);
      level_goal = goal;
      if (ramp_len == 0) begin
         ticks_to_go = 0;
         ramp_step   = 0;
         level_now   = goal;
      end else if (level_now == level_goal) begin
         ticks_to_go = 0;
         ramp_step   = 0;
      end else begin
         ticks_to_go = ramp_len;
         ramp_step   = (level_goal - level_now) / longint'(ramp_len);
      end
   endfunction

   function automatic level_type advance_level(input logic [CMD_BITS-1:0] cmd,
                                               input logic [VALUE_BITS-1:0] raw);
      longint    v;
      longint    sum;
      level_type r;
      v = longint'($signed(raw));
      case (cmd)
         CMD_TICK: begin
            if (ticks_to_go != 0) begin
               ticks_to_go--;
               level_now = level_goal - ramp_step * longint'(ticks_to_go);
            end
         end
         CMD_SET: retarget(v);
         CMD_ADD: begin
            sum = level_goal + v;
            if (sum > LEVEL_MAX) sum = LEVEL_MAX;
            if (sum < LEVEL_MIN) sum = LEVEL_MIN;
            retarget(sum);
         end
         default: begin
            level_now   = v;
            level_goal  = v;
            ticks_to_go = 0;
            ramp_step   = 0;
         end
      endcase
      r.level   = level_now[VALUE_BITS-1:0];
      r.ramping = (ticks_to_go != 0);
      return r;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'(($urandom_range(0, 2000) - 1000) <<< 16);
         3: return 32'($urandom_range(0, 32) - 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [VALUE_BITS-1:0] raw,
                            input logic typed, input level_type want);
      level_type predicted;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      predicted = advance_level(cmd, raw);
      levels_due.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_ramp_len(input logic [CSR_BITS-1:0] len);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ramp_len = int'(len);
   endtask

   // result side back-pressure
   initial begin
      @(negedge reset);
      forever begin
         if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      level_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (levels_due.size() == 0) begin
            report_mismatch($sformatf("unexpected rsp transaction %h", rsp_tdata));
         end else begin
            due = levels_due.pop_front();
            if (rsp_tdata[VALUE_BITS-1:0] !== due.level)
               report_mismatch($sformatf("value_out %h, expected %h",
                                         rsp_tdata[VALUE_BITS-1:0], due.level));
            if (rsp_tdata[VALUE_BITS] !== due.ramping)
               report_mismatch($sformatf("ramping %b, expected %b",
                                         rsp_tdata[VALUE_BITS], due.ramping));
            if (rsp_tdata[RSP_DATA_BITS-1:VALUE_BITS+1] !== '0)
               report_mismatch($sformatf("nonzero pad in %h", rsp_tdata));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("linear_ramp_smoother_top test failed");
      $finish;
   end

   initial begin
      int pick;
      logic [CMD_BITS-1:0] cmd;
      logic [CSR_BITS-1:0] len;

      level_now   = 0;
      level_goal  = 0;
      ramp_step   = 0;
      ticks_to_go = 0;
      ramp_len    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_drained();
            write_ramp_len(plan[i].value[CSR_BITS-1:0]);
         end else begin
            send_item(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         req_gaps   = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_stalls = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
         wait_drained();
         case (phase)
            0: len = 16'd1;
            1: len = 16'($urandom_range(2, 8));
            2: len = 16'd0;
            3: len = 16'hffff;
            4: len = 16'($urandom_range(2, 32));
            5: len = 16'($urandom_range(0, 65535));
            6: len = 16'd3;
            7: len = 16'($urandom_range(2, 16));
            8: len = 16'd1;
            default: len = 16'($urandom_range(2, 6));
         endcase
         write_ramp_len(len);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      cmd = CMD_TICK;
            else if (pick < 70) cmd = CMD_SET;
            else if (pick < 85) cmd = CMD_ADD;
            else                cmd = CMD_LOAD;
            send_item(cmd, pick_value(), 1'b0, '0);
         end
      end

      wait_drained();
      if (errors == 0) begin
         $display("linear_ramp_smoother_top test passed");
      end else begin
         $display("linear_ramp_smoother_top test failed");
      end
      $finish;
   end

endmodule
